// ===== rtl/core/i2c_pkg.sv =====
// ----------------------------------------------------------------------------
// i2c_pkg - im2col column generator shared definitions
// Register map, reset values and the structs passed between the sub-blocks.
// ----------------------------------------------------------------------------
package i2c_pkg;

  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int ADDR_FULL_W = 26;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_IN_DIMS     = 3'd0;
  localparam logic [2:0] REG_IN_CHANNELS = 3'd1;
  localparam logic [2:0] REG_OFM_DIMS    = 3'd2;
  localparam logic [2:0] REG_KERNEL_DIMS = 3'd3;
  localparam logic [2:0] REG_STRIDES     = 3'd4;
  localparam logic [2:0] REG_PADS        = 3'd5;
  localparam logic [2:0] REG_DILATIONS   = 3'd6;

  localparam logic [15:0] RST_IN_DIMS     = 16'd2056;
  localparam logic [7:0]  RST_IN_CHANNELS = 8'd1;
  localparam logic [15:0] RST_OFM_DIMS    = 16'd2056;
  localparam logic [7:0]  RST_KERNEL_DIMS = 8'd51;
  localparam logic [7:0]  RST_STRIDES     = 8'd17;
  localparam logic [7:0]  RST_PADS        = 8'd17;
  localparam logic [7:0]  RST_DILATIONS   = 8'd17;

  // Decoded geometry
  typedef struct packed {
    logic [7:0] ih;
    logic [7:0] iw;
    logic [7:0] ic;
    logic [7:0] oh;
    logic [7:0] ow;
    logic [3:0] kh;
    logic [3:0] kw;
    logic [3:0] sh;
    logic [3:0] sw;
    logic [3:0] pt;
    logic [3:0] pl;
    logic [3:0] dh;
    logic [3:0] dw;
  } i2c_cfg_t;

  // Store request from the address pipeline
  typedef struct packed {
    logic        vld;
    logic        load;
    logic        pad;
    logic        last;
    logic [31:0] data;
  } i2c_req_t;

endpackage

// ===== rtl/core/i2c_in_if.sv =====
// ----------------------------------------------------------------------------
// i2c_in_if - input item channel
// Valid/ready channel carrying load and generate items.
// ----------------------------------------------------------------------------
interface i2c_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] load_address;
  logic [31:0] load_value;

  modport source (output valid, mode, load_address, load_value, input ready);
  modport sink   (input valid, mode, load_address, load_value, output ready);
endinterface

// ===== rtl/core/i2c_out_if.sv =====
// ----------------------------------------------------------------------------
// i2c_out_if - column element channel
// Valid/ready channel carrying one im2col matrix element per transfer.
// ----------------------------------------------------------------------------
interface i2c_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] element_value;
  logic        is_padding;
  logic [15:0] source_address;
  logic        last;

  modport source (output valid, element_value, is_padding, source_address, last,
                  input ready);
  modport sink   (input valid, element_value, is_padding, source_address, last,
                  output ready);
endinterface

// ===== rtl/core/im2col_column_generator_top.sv =====
// ----------------------------------------------------------------------------
// im2col_column_generator_top - im2col column matrix generator
// Image word store plus a counter-driven address pipeline that streams the
// im2col matrix of the stored CHW image, one element per transfer.
// ----------------------------------------------------------------------------
// A generate item's element passes stage 1, stage 2, the request register and
//   the result register. Throughput: one item per cycle unless the result stalls;
//   set by the three-stage address pipeline feeding one registered-read store port.
// A stalled result freezes every stage, so input ready drops with it.
// Reset (sync, active low) clears counters, stage valids and loads register
//   reset values; the store is not cleared and holds garbage until written.
module im2col_column_generator_top import i2c_pkg::*; #(
  parameter int STORE_WORDS = 65536
) (
  input  logic                  clk,
  input  logic                  rst_n,
  i2c_in_if.sink                in_ch,
  i2c_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Store is addressed modulo its size; STORE_WORDS is taken as a power of two
  localparam int AW = $clog2(STORE_WORDS);

  i2c_cfg_t      cfg;
  i2c_req_t      req;
  logic [AW-1:0] req_addr;
  logic          adv;

  // Geometry registers
  i2c_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Counters and address arithmetic; loads pass through in order
  i2c_addr_gen #(.AW(AW)) u_gen (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .adv             (adv),
    .in_valid        (in_ch.valid),
    .in_mode         (in_ch.mode),
    .in_load_address (in_ch.load_address),
    .in_load_value   (in_ch.load_value),
    .req             (req),
    .req_addr        (req_addr)
  );

  // Store access and output register; reads and writes share one stage,
  // so a load is always seen by every later generate item
  i2c_store #(.DEPTH(STORE_WORDS), .AW(AW)) u_store (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (req),
    .req_addr       (req_addr),
    .out_ready      (out_ch.ready),
    .adv            (adv),
    .out_valid      (out_ch.valid),
    .element_value  (out_ch.element_value),
    .is_padding     (out_ch.is_padding),
    .source_address (out_ch.source_address),
    .last           (out_ch.last)
  );

  assign in_ch.ready = adv;

  // Checks
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_padding |->
      out_ch.element_value == 32'd0 && out_ch.source_address == 16'd0)
    else $error("padding element carries data");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(req) && $stable(req_addr))
    else $error("pipeline moved while result stalled");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid && !req.vld)
    else $error("valid set after reset");

endmodule

// ===== rtl/core/i2c_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// i2c_cfg_regs - configuration register file
// APB-style write/read of the seven geometry registers.
// ----------------------------------------------------------------------------
module i2c_cfg_regs import i2c_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output i2c_cfg_t              cfg
);

  logic [15:0] in_dims_r, in_dims_nxt;
  logic [7:0]  in_channels_r, in_channels_nxt;
  logic [15:0] ofm_dims_r, ofm_dims_nxt;
  logic [7:0]  kernel_dims_r, kernel_dims_nxt;
  logic [7:0]  strides_r, strides_nxt;
  logic [7:0]  pads_r, pads_nxt;
  logic [7:0]  dilations_r, dilations_nxt;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_comb begin
    in_dims_nxt     = in_dims_r;
    in_channels_nxt = in_channels_r;
    ofm_dims_nxt    = ofm_dims_r;
    kernel_dims_nxt = kernel_dims_r;
    strides_nxt     = strides_r;
    pads_nxt        = pads_r;
    dilations_nxt   = dilations_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_IN_DIMS:     in_dims_nxt     = pwdata[15:0];
        REG_IN_CHANNELS: in_channels_nxt = pwdata[7:0];
        REG_OFM_DIMS:    ofm_dims_nxt    = pwdata[15:0];
        REG_KERNEL_DIMS: kernel_dims_nxt = pwdata[7:0];
        REG_STRIDES:     strides_nxt     = pwdata[7:0];
        REG_PADS:        pads_nxt        = pwdata[7:0];
        REG_DILATIONS:   dilations_nxt   = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_dims_r     <= RST_IN_DIMS;
      in_channels_r <= RST_IN_CHANNELS;
      ofm_dims_r    <= RST_OFM_DIMS;
      kernel_dims_r <= RST_KERNEL_DIMS;
      strides_r     <= RST_STRIDES;
      pads_r        <= RST_PADS;
      dilations_r   <= RST_DILATIONS;
    end else begin
      in_dims_r     <= in_dims_nxt;
      in_channels_r <= in_channels_nxt;
      ofm_dims_r    <= ofm_dims_nxt;
      kernel_dims_r <= kernel_dims_nxt;
      strides_r     <= strides_nxt;
      pads_r        <= pads_nxt;
      dilations_r   <= dilations_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IN_DIMS:     prdata = 32'(in_dims_r);
      REG_IN_CHANNELS: prdata = 32'(in_channels_r);
      REG_OFM_DIMS:    prdata = 32'(ofm_dims_r);
      REG_KERNEL_DIMS: prdata = 32'(kernel_dims_r);
      REG_STRIDES:     prdata = 32'(strides_r);
      REG_PADS:        prdata = 32'(pads_r);
      REG_DILATIONS:   prdata = 32'(dilations_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.ih = in_dims_r[15:8];
  assign cfg.iw = in_dims_r[7:0];
  assign cfg.ic = in_channels_r;
  assign cfg.oh = ofm_dims_r[15:8];
  assign cfg.ow = ofm_dims_r[7:0];
  assign cfg.kh = kernel_dims_r[7:4];
  assign cfg.kw = kernel_dims_r[3:0];
  assign cfg.sh = strides_r[7:4];
  assign cfg.sw = strides_r[3:0];
  assign cfg.pt = pads_r[7:4];
  assign cfg.pl = pads_r[3:0];
  assign cfg.dh = dilations_r[7:4];
  assign cfg.dw = dilations_r[3:0];

endmodule

// ===== rtl/core/i2c_addr_gen.sv =====
// ----------------------------------------------------------------------------
// i2c_addr_gen - position counters and tap address pipeline
// Walks the column matrix and turns each position into a store address over
// three register stages; load items ride the same stages to keep order.
// ----------------------------------------------------------------------------
module i2c_addr_gen import i2c_pkg::*; #(
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  i2c_cfg_t      cfg,
  input  logic          adv,
  input  logic          in_valid,
  input  logic          in_mode,
  input  logic [15:0]   in_load_address,
  input  logic [31:0]   in_load_value,
  output i2c_req_t      req,
  output logic [AW-1:0] req_addr
);

  // counters
  logic [7:0] ocol_r, ocol_nxt, orow_r, orow_nxt, ch_r, ch_nxt;
  logic [3:0] tcol_r, tcol_nxt, trow_r, trow_nxt;
  logic [7:0] e_ocol, e_orow, e_ch;
  logic [3:0] e_tcol, e_trow;
  logic       empty, beyond, take, gen;
  logic       w_ocol, w_orow, w_tcol, w_trow, w_ch, fin;

  // stage 1
  logic        s1_vld_r, s1_load_r, s1_last_r;
  logic [31:0] s1_data_r;
  logic [15:0] s1_laddr_r;
  logic [7:0]  s1_prd_r, s1_pcd_r;
  logic [11:0] s1_prs_r, s1_pcs_r;
  logic [15:0] s1_ihc_r;

  // stage 2
  logic        s2_vld_r, s2_load_r, s2_last_r, s2_pad_r;
  logic [31:0] s2_data_r;
  logic [15:0] s2_laddr_r;
  logic [16:0] s2_rowc_r;
  logic [12:0] s2_col_r;
  logic [12:0] row_sum, col_sum, row_u, col_u;
  logic        row_in, col_in;

  // stage 3
  logic [ADDR_FULL_W-1:0] addr_full;
  i2c_req_t               req_r;
  logic [AW-1:0]          req_addr_r;

  always_comb begin
    empty  = (cfg.ow == 8'd0) || (cfg.oh == 8'd0) || (cfg.kw == 4'd0) ||
             (cfg.kh == 4'd0) || (cfg.ic == 8'd0);
    beyond = (ocol_r >= cfg.ow) || (orow_r >= cfg.oh) || (tcol_r >= cfg.kw) ||
             (trow_r >= cfg.kh) || (ch_r >= cfg.ic);
    e_ocol = beyond ? 8'd0 : ocol_r;
    e_orow = beyond ? 8'd0 : orow_r;
    e_tcol = beyond ? 4'd0 : tcol_r;
    e_trow = beyond ? 4'd0 : trow_r;
    e_ch   = beyond ? 8'd0 : ch_r;
    w_ocol = (e_ocol == cfg.ow - 8'd1);
    w_orow = (e_orow == cfg.oh - 8'd1);
    w_tcol = (e_tcol == cfg.kw - 4'd1);
    w_trow = (e_trow == cfg.kh - 4'd1);
    w_ch   = (e_ch   == cfg.ic - 8'd1);
    fin    = w_ocol && w_orow && w_tcol && w_trow && w_ch;
    take   = in_valid && adv;
    gen    = take && in_mode && !empty;

    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    tcol_nxt = tcol_r;
    trow_nxt = trow_r;
    ch_nxt   = ch_r;
    if (gen) begin
      ocol_nxt = w_ocol ? 8'd0 : e_ocol + 8'd1;
      orow_nxt = e_orow;
      tcol_nxt = e_tcol;
      trow_nxt = e_trow;
      ch_nxt   = e_ch;
      if (w_ocol) begin
        orow_nxt = w_orow ? 8'd0 : e_orow + 8'd1;
        if (w_orow) begin
          tcol_nxt = w_tcol ? 4'd0 : e_tcol + 4'd1;
          if (w_tcol) begin
            trow_nxt = w_trow ? 4'd0 : e_trow + 4'd1;
            if (w_trow) begin
              ch_nxt = w_ch ? 8'd0 : e_ch + 8'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocol_r <= '0;
      orow_r <= '0;
      tcol_r <= '0;
      trow_r <= '0;
      ch_r   <= '0;
    end else begin
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
      tcol_r <= tcol_nxt;
      trow_r <= trow_nxt;
      ch_r   <= ch_nxt;
    end
  end

  // stage 1: partial products of the tap position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= take && (!in_mode || !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_load_r  <= !in_mode;
      s1_last_r  <= fin;
      s1_data_r  <= in_load_value;
      s1_laddr_r <= in_load_address;
      s1_prd_r   <= 8'(e_trow) * 8'(cfg.dh);
      s1_prs_r   <= 12'(e_orow) * 12'(cfg.sh);
      s1_pcd_r   <= 8'(e_tcol) * 8'(cfg.dw);
      s1_pcs_r   <= 12'(e_ocol) * 12'(cfg.sw);
      s1_ihc_r   <= 16'(cfg.ih) * 16'(e_ch);
    end
  end

  // stage 2: pad offset, bounds check, row base
  always_comb begin
    row_sum = 13'(s1_prd_r) + 13'(s1_prs_r);
    col_sum = 13'(s1_pcd_r) + 13'(s1_pcs_r);
    row_u   = row_sum - 13'(cfg.pt);
    col_u   = col_sum - 13'(cfg.pl);
    row_in  = (row_sum >= 13'(cfg.pt)) && (row_u < 13'(cfg.ih));
    col_in  = (col_sum >= 13'(cfg.pl)) && (col_u < 13'(cfg.iw));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_load_r  <= s1_load_r;
      s2_last_r  <= s1_last_r;
      s2_data_r  <= s1_data_r;
      s2_laddr_r <= s1_laddr_r;
      s2_pad_r   <= !(row_in && col_in);
      s2_rowc_r  <= 17'(row_u) + 17'(s1_ihc_r);
      s2_col_r   <= col_u;
    end
  end

  // stage 3: linear address, wrapped to the store size
  assign addr_full = ADDR_FULL_W'(cfg.iw) * ADDR_FULL_W'(s2_rowc_r) +
                     ADDR_FULL_W'(s2_col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r.vld <= 1'b0;
    end else if (adv) begin
      req_r.vld <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      req_r.load <= s2_load_r;
      req_r.pad  <= s2_pad_r && !s2_load_r;
      req_r.last <= s2_last_r;
      req_r.data <= s2_data_r;
      req_addr_r <= s2_load_r ? AW'(s2_laddr_r) : addr_full[AW-1:0];
    end
  end

  assign req      = req_r;
  assign req_addr = req_addr_r;

endmodule

// ===== rtl/core/i2c_store.sv =====
// ----------------------------------------------------------------------------
// i2c_store - image store and result register
// Single-port word store with registered read; holds the result until taken.
// ----------------------------------------------------------------------------
module i2c_store import i2c_pkg::*; #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  i2c_req_t      req,
  input  logic [AW-1:0] req_addr,
  input  logic          out_ready,
  output logic          adv,
  output logic          out_valid,
  output logic [31:0]   element_value,
  output logic          is_padding,
  output logic [15:0]   source_address,
  output logic          last
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_q_r;
  logic        out_vld_r, pad_r, last_r;
  logic [15:0] src_r;

  assign adv = !out_vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (req.vld && req.load) begin
        mem[req_addr] <= req.data;
      end
      rd_q_r <= mem[req_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= req.vld && !req.load;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pad_r  <= req.pad;
      last_r <= req.last;
      src_r  <= req.pad ? 16'd0 : 16'(req_addr);
    end
  end

  assign out_valid      = out_vld_r;
  assign element_value  = pad_r ? 32'd0 : rd_q_r;
  assign is_padding     = pad_r;
  assign source_address = src_r;
  assign last           = last_r;

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - im2col column generator bench
// Drives load and generate transfers into the image store and checks every
// column element against a predictor built into a small scoreboard class.
// It steps through many geometries over the register port, with the
// extremes among them, and throttles both channels at random.
// ----------------------------------------------------------------------------
module testbench import i2c_pkg::*; ();

  // Item modes and the one register index past the end of the map
  localparam logic       MODE_LOAD  = 1'b0;
  localparam logic       MODE_GEN   = 1'b1;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  localparam int RANDOM_ITEMS = 600;
  localparam int LATENCY      = 4;            // generate in to element out
  localparam int SETTLE       = 2 * LATENCY;  // quiet time before a register write
  localparam int HOLD_CYCLES  = 300;          // long output stall
  localparam int HOLD_AFTER   = 450;          // random items before that stall
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 100;

  // One column matrix element as seen on the result channel
  typedef struct packed {
    logic [31:0] value;
    logic        padding;
    logic [15:0] source;
    logic        last;
  } column_elem_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow registers, counters and image store, plus the queue of
  // elements still owed by the block.
  // --------------------------------------------------------------------------
  class column_scoreboard;
    logic [15:0]  in_dims, ofm_dims;
    logic [7:0]   in_channels, kernel_dims, strides, pads, dilations;
    int unsigned  out_col, out_row, tap_col, tap_row, channel;
    logic [31:0]  image [65536];
    bit           written [65536];
    column_elem_t pending [$];
    int           errors, loads, elements, pad_taps, matrix_ends;

    function new();
      in_dims     = RST_IN_DIMS;
      in_channels = RST_IN_CHANNELS;
      ofm_dims    = RST_OFM_DIMS;
      kernel_dims = RST_KERNEL_DIMS;
      strides     = RST_STRIDES;
      pads        = RST_PADS;
      dilations   = RST_DILATIONS;
      out_col = 0; out_row = 0; tap_col = 0; tap_row = 0; channel = 0;
      errors = 0; loads = 0; elements = 0; pad_taps = 0; matrix_ends = 0;
    endfunction

    task report(input string msg);
      // printing is capped so a broken block cannot flood the log
      if (errors < MAX_REPORTS) $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    function void set_register(input logic [2:0] idx, input logic [31:0] data);
      case (idx)
        REG_IN_DIMS:     in_dims     = data[15:0];
        REG_IN_CHANNELS: in_channels = data[7:0];
        REG_OFM_DIMS:    ofm_dims    = data[15:0];
        REG_KERNEL_DIMS: kernel_dims = data[7:0];
        REG_STRIDES:     strides     = data[7:0];
        REG_PADS:        pads        = data[7:0];
        REG_DILATIONS:   dilations   = data[7:0];
        default: ;
      endcase
    endfunction

    function i2c_cfg_t geometry();
      i2c_cfg_t g;
      g.ih = in_dims[15:8];      g.iw = in_dims[7:0];
      g.ic = in_channels;
      g.oh = ofm_dims[15:8];     g.ow = ofm_dims[7:0];
      g.kh = kernel_dims[7:4];   g.kw = kernel_dims[3:0];
      g.sh = strides[7:4];       g.sw = strides[3:0];
      g.pt = pads[7:4];          g.pl = pads[3:0];
      g.dh = dilations[7:4];     g.dw = dilations[3:0];
      return g;
    endfunction

    function bit empty_matrix();
      i2c_cfg_t g;
      g = geometry();
      return g.ow == 0 || g.oh == 0 || g.kw == 0 || g.kh == 0 || g.ic == 0;
    endfunction

    function bit out_of_range();
      i2c_cfg_t g;
      g = geometry();
      return out_col >= g.ow || out_row >= g.oh || tap_col >= g.kw ||
             tap_row >= g.kh || channel >= g.ic;
    endfunction

    // Tap of the next generate, counters taken as cleared when out of range.
    // Leaves the state alone so the driver can look ahead.
    function void locate(output bit emits, output bit in_img,
                         output logic [15:0] addr, output bit fin);
      i2c_cfg_t    g;
      int unsigned oc, orow, tc, tr, ch, full;
      int          row, col;
      g = geometry();
      emits  = !empty_matrix();
      in_img = 1'b0;
      addr   = '0;
      fin    = 1'b0;
      if (!emits) return;
      if (out_of_range()) begin
        oc = 0; orow = 0; tc = 0; tr = 0; ch = 0;
      end else begin
        oc = out_col; orow = out_row; tc = tap_col; tr = tap_row; ch = channel;
      end
      row = int'(tr * g.dh + orow * g.sh) - int'(g.pt);
      col = int'(tc * g.dw + oc * g.sw) - int'(g.pl);
      in_img = row >= 0 && row < int'(g.ih) && col >= 0 && col < int'(g.iw);
      if (in_img) begin
        full = g.iw * (unsigned'(row) + g.ih * ch) + unsigned'(col);
        addr = full[15:0];
      end
      fin = oc + 1 == g.ow && orow + 1 == g.oh && tc + 1 == g.kw &&
            tr + 1 == g.kh && ch + 1 == g.ic;
    endfunction

    function void note_input(input logic mode, input logic [15:0] a,
                             input logic [31:0] v);
      i2c_cfg_t     g;
      bit           emits, in_img, fin;
      logic [15:0]  addr;
      column_elem_t want;
      if (mode == MODE_LOAD) begin
        image[a]   = v;
        written[a] = 1'b1;
        loads++;
        return;
      end
      locate(emits, in_img, addr, fin);
      if (!emits) return;
      if (out_of_range()) begin
        out_col = 0; out_row = 0; tap_col = 0; tap_row = 0; channel = 0;
      end
      want.value   = in_img ? image[addr] : 32'h0;
      want.padding = !in_img;
      want.source  = addr;
      want.last    = fin;
      pending.push_back(want);
      g = geometry();
      // output column fastest, input channel slowest
      if (++out_col >= g.ow) begin
        out_col = 0;
        if (++out_row >= g.oh) begin
          out_row = 0;
          if (++tap_col >= g.kw) begin
            tap_col = 0;
            if (++tap_row >= g.kh) begin
              tap_row = 0;
              if (++channel >= g.ic) channel = 0;
            end
          end
        end
      end
    endfunction

    task check_element(input column_elem_t got);
      column_elem_t want;
      if (pending.size() == 0) begin
        report($sformatf("element %h with nothing outstanding", got.value));
        return;
      end
      want = pending.pop_front();
      elements++;
      if (want.padding) pad_taps++;
      if (want.last) matrix_ends++;
      if (got.value !== want.value)
        report($sformatf("element_value %h, want %h", got.value, want.value));
      if (got.padding !== want.padding)
        report($sformatf("is_padding %b, want %b", got.padding, want.padding));
      if (got.source !== want.source)
        report($sformatf("source_address %h, want %h", got.source, want.source));
      if (got.last !== want.last)
        report($sformatf("last %b, want %b", got.last, want.last));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, block under test
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  i2c_in_if  in_ch ();
  i2c_out_if out_ch ();

  logic                  psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  im2col_column_generator_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  column_scoreboard sb;

  // Throttle levels, percent of cycles spent idle on each side
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_go = 1'b0;   // asks the receiver for its one long stall
  int cycle_count = 0;

  // --------------------------------------------------------------------------
  // Receiver: random ready, plus one long stall timed by its own counter so
  // the block backs up and holds off its input.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Result monitor: values sampled at the edge are the pre-edge ones
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_element('{value:   out_ch.element_value,
                         padding: out_ch.is_padding,
                         source:  out_ch.source_address,
                         last:    out_ch.last});
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input channel
  // --------------------------------------------------------------------------
  // One cycle with valid low; the payload is scrambled meanwhile
  task automatic idle_cycle();
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= 1'($urandom());
    in_ch.load_address <= 16'($urandom());
    in_ch.load_value   <= $urandom();
    @(posedge clk);
  endtask

  // Offer one item after a random gap, hold it until the transfer, then
  // hand it to the predictor. Valid is left high for a back-to-back item.
  task automatic offer(input logic m, input logic [15:0] a, input logic [31:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) idle_cycle();
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= m;
    in_ch.load_address <= a;
    in_ch.load_value   <= v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_input(m, a, v);
  endtask

  // Next column element; if its tap hits a word never loaded, load it first
  // so no unwritten store word is ever read.
  task automatic generate_one();
    bit          emits, in_img, fin;
    logic [15:0] addr;
    sb.locate(emits, in_img, addr, fin);
    if (emits && in_img && !sb.written[addr])
      offer(MODE_LOAD, addr, $urandom());
    offer(MODE_GEN, 16'($urandom()), $urandom());
  endtask

  // Stop sending, wait for every owed element, then let loads settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Register port: setup cycle then access cycle. psel is left high between
  // back-to-back writes and dropped by cfg_release.
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_register(idx, data);
  endtask

  task automatic cfg_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Writes all seven registers; unused upper bits carry noise
  task automatic apply_geometry(input i2c_cfg_t g);
    write_reg(REG_IN_DIMS,     {16'($urandom()), g.ih, g.iw});
    write_reg(REG_IN_CHANNELS, {24'($urandom()), g.ic});
    write_reg(REG_OFM_DIMS,    {16'($urandom()), g.oh, g.ow});
    write_reg(REG_KERNEL_DIMS, {24'($urandom()), g.kh, g.kw});
    write_reg(REG_STRIDES,     {24'($urandom()), g.sh, g.sw});
    write_reg(REG_PADS,        {24'($urandom()), g.pt, g.pl});
    write_reg(REG_DILATIONS,   {24'($urandom()), g.dh, g.dw});
    cfg_release();
  endtask

  // Mostly small geometries so matrix ends come round often; now and then
  // the all-ones extreme, zero strides and dilations, an empty matrix,
  // heavy padding or a huge image that wraps the store address.
  function automatic i2c_cfg_t pick_geometry();
    i2c_cfg_t    g;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    g.ih = 8'($urandom_range(0, 6));  g.iw = 8'($urandom_range(0, 6));
    g.ic = 8'($urandom_range(1, 3));
    g.oh = 8'($urandom_range(1, 4));  g.ow = 8'($urandom_range(1, 4));
    g.kh = 4'($urandom_range(1, 3));  g.kw = 4'($urandom_range(1, 3));
    g.sh = 4'($urandom_range(0, 2));  g.sw = 4'($urandom_range(0, 2));
    g.pt = 4'($urandom_range(0, 2));  g.pl = 4'($urandom_range(0, 2));
    g.dh = 4'($urandom_range(0, 2));  g.dw = 4'($urandom_range(0, 2));
    case (pick)
      0: g = '1;
      1: begin
        g.sh = '0; g.sw = '0; g.dh = '0; g.dw = '0; g.pt = '0; g.pl = '0;
      end
      2: case ($urandom_range(0, 3))
        0: g.ow = '0;
        1: g.oh = '0;
        2: g.kw = '0;
        default: g.kh = '0;
      endcase
      3: begin
        g.pt = 4'($urandom_range(8, 15));
        g.pl = 4'($urandom_range(8, 15));
      end
      4: begin
        g.ih = 8'hFF; g.iw = 8'hFF; g.ic = 8'($urandom_range(2, 255));
      end
      default: ;
    endcase
    return g;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    i2c_cfg_t g;
    int       random_start, random_done, settings, n;

    sb = new();
    settings = 0;

    in_ch.valid        <= 1'b0;
    in_ch.mode         <= MODE_LOAD;
    in_ch.load_address <= '0;
    in_ch.load_value   <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part -----------------------------------------------------
    send_idle_pct = 15;
    recv_idle_pct = 84;

    // reset geometry: 8x8 image, 3x3 kernel, unit stride, pad and dilation.
    // Field extremes on the load path first.
    offer(MODE_LOAD, 16'h0000, 32'h0000_0000);
    offer(MODE_LOAD, 16'hFFFF, 32'hFFFF_FFFF);
    offer(MODE_LOAD, 16'h5A5A, 32'hA5A5_5A5A);
    repeat (4) generate_one();

    // shrink the output width under the live counters: next generate must
    // restart at the origin; nine items run one past the matrix end
    drain();
    g = '{ih: 8'd8, iw: 8'd8, ic: 8'd2, oh: 8'd2, ow: 8'd1, kh: 4'd1, kw: 4'd2,
          sh: 4'd1, sw: 4'd1, pt: 4'd1, pl: 4'd1, dh: 4'd1, dw: 4'd1};
    apply_geometry(g);
    settings++;
    repeat (9) generate_one();

    // zero kernel width makes the matrix empty; the write past the register
    // map must change nothing
    drain();
    write_reg(REG_KERNEL_DIMS, 32'h0000_0020);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    cfg_release();
    repeat (2) generate_one();

    // 255x255 image, three channels, zero stride and dilation: the third
    // channel's base address wraps round the store
    drain();
    g = '{ih: 8'hFF, iw: 8'hFF, ic: 8'd3, oh: 8'd1, ow: 8'd1, kh: 4'd1, kw: 4'd1,
          sh: 4'd0, sw: 4'd0, pt: 4'd0, pl: 4'd0, dh: 4'd0, dw: 4'd0};
    apply_geometry(g);
    settings++;
    repeat (3) generate_one();

    // ---- random part ---------------------------------------------------------
    // Each phase: quiet block, fresh geometry, then a burst of mostly
    // generates with some stray loads to random addresses.
    random_start = sb.loads + sb.elements + sb.pending.size();
    random_done  = 0;
    while (random_done < RANDOM_ITEMS) begin
      if (random_done < RANDOM_ITEMS / 3) begin
        send_idle_pct = 15; recv_idle_pct = 84;
      end else if (random_done < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 84; recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;  recv_idle_pct = 0;
      end
      drain();
      apply_geometry(pick_geometry());
      settings++;
      n = $urandom_range(20, 60);
      if (random_done >= HOLD_AFTER && !hold_go) begin
        hold_go <= 1'b1;
        n = 60;
      end
      repeat (n) begin
        if ($urandom_range(0, 99) < 12)
          offer(MODE_LOAD, 16'($urandom()), $urandom());
        else
          generate_one();
      end
      random_done = sb.loads + sb.elements + sb.pending.size() - random_start;
    end

    // ---- wind down -----------------------------------------------------------
    drain();
    repeat (2 * LATENCY) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d elements never arrived", sb.pending.size()));

    $display("covered %0d geometries, %0d image loads, %0d column elements",
             settings, sb.loads, sb.elements);
    $display("  of which %0d padding taps and %0d matrix ends", sb.pad_taps,
             sb.matrix_ends);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/i2c_pkg.sv
rtl/core/i2c_in_if.sv
rtl/core/i2c_out_if.sv
rtl/core/i2c_cfg_regs.sv
rtl/core/i2c_addr_gen.sv
rtl/core/i2c_store.sv
rtl/core/im2col_column_generator_top.sv
bench/testbench.sv
